### hdl/rmt_pkg.sv
package rmt_pkg;

  // Width of the sample and mode value ports.
  localparam int SAMPLE_BITS = 10;
  // Width of the reported mode count port.
  localparam int MODE_COUNT_BITS = 16;

  // Histogram geometry.
  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int TABLE_DEPTH = 1 << VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam value_t VALUE_LAST = '1;
  localparam count_t COUNT_MAX = '1;

endpackage

### hdl/rmt_count_ram.sv
module rmt_count_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/running_mode_tracker.sv
// Streaming mode tracker. Every input beat carries one unsigned sample; the
// block raises that sample's count in a 1024-entry histogram of saturating
// 16-bit counts and returns one output beat holding the running mode (the
// most frequent sample so far, the larger sample winning ties) and its count.
// The histogram lives in a single-port-write, single-port-read memory. The
// sample's count is read from it at the edge the input beat is accepted into
// stage one; at the edge stage one moves on, which waits while the output
// register is full and stalled, the count is incremented, written back and
// compared with the best count, and the result lands in the output register.
// One beat is accepted every cycle for as long as the output side keeps
// taking results, repeated samples included: the write of the previous beat
// is forwarded to the next one, so no bubble is needed between equal
// samples. After reset the block sweeps the memory to zero, one entry per
// cycle, and holds in_stall high throughout the sweep, so no beat is accepted
// before it ends.
module running_mode_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmt_pkg::SAMPLE_BITS-1:0]     sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rmt_pkg::SAMPLE_BITS-1:0]     mode_value,
  output logic [rmt_pkg::MODE_COUNT_BITS-1:0] mode_count
);

  import rmt_pkg::*;

  // Clearing sweep over the histogram after reset.
  logic   clearing;
  value_t clr_idx;

  // Stage one: the sample whose count is being read from the memory.
  logic   valid1;
  value_t value1;

  // The most recent histogram write, forwarded to the next sample.
  logic   last_wr_valid;
  value_t last_wr_addr;
  count_t last_wr_data;

  count_t rd_data;

  // Running mode.
  value_t best_value;
  count_t best_count;
  value_t best_value_next;
  count_t best_count_next;

  count_t count_old;
  count_t count_new;

  logic   in_accept;
  logic   fire;

  logic   ram_we;
  value_t ram_waddr;
  count_t ram_wdata;

  assign in_accept = in_valid && !in_stall;

  // Stage one moves on when the output register is empty or being emptied.
  assign fire = valid1 && (!out_valid || !out_stall);

  // After the sweep, a new beat enters when stage one is empty or moving on.
  assign in_stall = clearing || (valid1 && !fire);

  // The memory returns the value from before any write at the same edge, so
  // the last write is forwarded when it hit the same entry.
  always_comb begin
    if (last_wr_valid && (last_wr_addr == value1)) begin
      count_old = last_wr_data;
    end else begin
      count_old = rd_data;
    end

    if (count_old == COUNT_MAX) begin
      count_new = count_old;
    end else begin
      count_new = count_t'(count_old + 1'b1);
    end

    best_value_next = best_value;
    best_count_next = best_count;
    if (count_new > best_count) begin
      best_value_next = value1;
      best_count_next = count_new;
    end else if ((count_new == best_count) && (value1 > best_value)) begin
      best_value_next = value1;
    end
  end

  // The clearing sweep and the count write-back share the write port; the
  // sweep never overlaps a write-back since no beat enters during it.
  always_comb begin
    ram_we    = clearing || fire;
    ram_waddr = clearing ? clr_idx : value1;
    ram_wdata = clearing ? '0 : count_new;
  end

  rmt_count_ram #(
    .ADDR_BITS(VALUE_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(value_t'(sample_value)),
    .rdata(rd_data)
  );

  // Control state and the running mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_idx       <= '0;
      valid1        <= 1'b0;
      out_valid     <= 1'b0;
      last_wr_valid <= 1'b0;
      best_value    <= '0;
      best_count    <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= value_t'(clr_idx + 1'b1);
        if (clr_idx == VALUE_LAST) begin
          clearing <= 1'b0;
        end
      end

      if (in_accept) begin
        valid1 <= 1'b1;
      end else if (fire) begin
        valid1 <= 1'b0;
      end

      if (fire) begin
        out_valid     <= 1'b1;
        last_wr_valid <= 1'b1;
        best_value    <= best_value_next;
        best_count    <= best_count_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      value1 <= value_t'(sample_value);
    end
    if (fire) begin
      last_wr_addr <= value1;
      last_wr_data <= count_new;
      mode_value   <= SAMPLE_BITS'(best_value_next);
      mode_count   <= MODE_COUNT_BITS'(best_count_next);
    end
  end

  // No beat enters while the histogram is still being cleared.
  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (rst) clearing |-> in_stall
  ) else $error("input beat accepted during histogram clearing");

  // Every reported mode has been seen at least once.
  a_mode_count_nonzero : assert property (
    @(posedge clk) disable iff (rst) out_valid |-> (mode_count != '0)
  ) else $error("result reported with a zero mode count");

  // The best count never goes down.
  a_best_count_monotonic : assert property (
    @(posedge clk) disable iff (rst) 1'b1 |=> (best_count >= $past(best_count))
  ) else $error("best count decreased");

  // An accepted beat occupies stage one in the next cycle.
  a_accept_fills_stage : assert property (
    @(posedge clk) disable iff (rst) in_accept |=> valid1
  ) else $error("accepted beat lost before stage one");

  // A beat leaving stage one always produces a result.
  a_fire_produces_result : assert property (
    @(posedge clk) disable iff (rst) fire |=> out_valid
  ) else $error("stage one advanced without a result");

endmodule
